// File: hdl/frame_cycle_singularity_test_core_assert.svh
// ----------------------------------------------------------------------------
// frame cycle singularity test assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef FRAME_CYCLE_SINGULARITY_TEST_CORE_ASSERT_SVH
`define FRAME_CYCLE_SINGULARITY_TEST_CORE_ASSERT_SVH

// condition must never hold
`define FCST_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

// same-cycle implication
`define FCST_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: hdl/fcst_pkg.sv
// ----------------------------------------------------------------------------
// fcst_pkg
// types and constants shared by the frame cycle singularity test blocks
// ----------------------------------------------------------------------------
package fcst_pkg;

	localparam int QUEUE_DEPTH = 8;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// signed axis permutation: perm[i] is the target axis, sgn[i] the flip
	typedef struct packed {
		logic [2:0][1:0] perm;
		logic [2:0]      sgn;
	} fcst_map_t;

	// one classified frame handed from front to back
	typedef struct packed {
		logic      has_step;
		logic      closes;
		fcst_map_t step_a;
		fcst_map_t step_b;
	} fcst_step_t;

	localparam fcst_map_t IDENT_MAP = '{perm: {2'd2, 2'd1, 2'd0}, sgn: 3'b000};

	function automatic logic [1:0] row_of(input logic [3:0] k);
		logic [1:0] r;
		case (k)
			4'd0, 4'd1, 4'd2: r = 2'd0;
			4'd3, 4'd4, 4'd5: r = 2'd1;
			4'd6, 4'd7, 4'd8: r = 2'd2;
			default:          r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] col_of(input logic [3:0] k);
		logic [1:0] c;
		case (k)
			4'd0, 4'd3, 4'd6: c = 2'd0;
			4'd1, 4'd4, 4'd7: c = 2'd1;
			4'd2, 4'd5, 4'd8: c = 2'd2;
			default:          c = 2'd0;
		endcase
		return c;
	endfunction

	// cycle := step * cycle
	function automatic fcst_map_t compose(input fcst_map_t cyc, input fcst_map_t step);
		fcst_map_t r;
		r = IDENT_MAP;
		for (int i = 0; i < 3; i++) begin
			case (cyc.perm[i])
				2'd0: begin
					r.perm[i] = step.perm[0];
					r.sgn[i]  = step.sgn[0] ^ cyc.sgn[i];
				end
				2'd1: begin
					r.perm[i] = step.perm[1];
					r.sgn[i]  = step.sgn[1] ^ cyc.sgn[i];
				end
				2'd2: begin
					r.perm[i] = step.perm[2];
					r.sgn[i]  = step.sgn[2] ^ cyc.sgn[i];
				end
				default: begin
					r.perm[i] = 2'd0;
					r.sgn[i]  = cyc.sgn[i];
				end
			endcase
		end
		return r;
	endfunction

endpackage

// File: hdl/fcst_match.sv
// ----------------------------------------------------------------------------
// fcst_match
// two-stage greedy matching of nine absolute dot products
// ----------------------------------------------------------------------------
module fcst_match #(
	parameter int MAG_W = 34
) (
	input  logic                  clk,
	input  logic [MAG_W-1:0]      mag [9],
	input  logic [8:0]            pos,
	output fcst_pkg::fcst_map_t   map_s4
);
	import fcst_pkg::*;

	logic [MAG_W-1:0] mag_s3 [9];
	logic [8:0]       pos_s3;
	logic [1:0]       fi_s3, fj_s3;

	logic [MAG_W-1:0] best;
	logic [3:0]       best_k;

	// first pair: largest, strict compare, row-major
	always_comb begin
		best   = mag[0];
		best_k = 4'd0;
		for (int k = 1; k < 9; k++) begin
			if (mag[k] > best) begin
				best   = mag[k];
				best_k = 4'(k);
			end
		end
	end

	always_ff @(posedge clk) begin
		mag_s3 <= mag;
		pos_s3 <= pos;
		fi_s3  <= row_of(best_k);
		fj_s3  <= col_of(best_k);
	end

	logic             found;
	logic [MAG_W-1:0] best2;
	logic [1:0]       si, sj, tj;
	fcst_map_t        m;
	logic [3:0]       pidx;

	// second pair among unused rows and columns, third is what is left
	always_comb begin
		found = 1'b0;
		best2 = '0;
		si    = 2'd0;
		sj    = 2'd0;
		pidx  = '0;
		m     = IDENT_MAP;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (2'(i) != fi_s3 && 2'(j) != fj_s3 &&
				    (!found || mag_s3[i*3+j] > best2)) begin
					best2 = mag_s3[i*3+j];
					si    = 2'(i);
					sj    = 2'(j);
					found = 1'b1;
				end
			end
		end
		tj = 2'd3 - fj_s3 - sj;
		for (int i = 0; i < 3; i++) begin
			if (2'(i) == fi_s3)
				m.perm[i] = fj_s3;
			else if (2'(i) == si)
				m.perm[i] = sj;
			else
				m.perm[i] = tj;
			pidx     = 4'(i * 3) + {2'b00, m.perm[i]};
			m.sgn[i] = !pos_s3[pidx];
		end
	end

	always_ff @(posedge clk) begin
		map_s4 <= m;
	end

endmodule

// File: hdl/fcst_front.sv
// ----------------------------------------------------------------------------
// fcst_front
// accepts frames, keeps first and previous frame, computes both matchings
// ----------------------------------------------------------------------------
module fcst_front #(
	parameter int COMP_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        acc,
	input  logic signed [COMP_BITS-1:0] frame [9],
	input  logic                        closes,
	output logic [2:0]                  inflight,
	output logic                        push,
	output fcst_pkg::fcst_step_t        step
);
	import fcst_pkg::*;

	localparam int PW  = 2 * COMP_BITS;
	localparam int MAG_W = PW + 2;

	logic                        have_first_q;
	logic signed [COMP_BITS-1:0] first_q [9];
	logic signed [COMP_BITS-1:0] prev_q  [9];
	logic signed [COMP_BITS-1:0] back_ref [9];

	logic v_s1, v_s2, v_s3, v_s4;
	logic has_s1, has_s2, has_s3, has_s4;
	logic cls_s1, cls_s2, cls_s3, cls_s4;

	logic signed [PW-1:0] prod_a_s1 [9][3];
	logic signed [PW-1:0] prod_b_s1 [9][3];
	logic [MAG_W-1:0]     mag_a_s2 [9];
	logic [MAG_W-1:0]     mag_b_s2 [9];
	logic [8:0]           pos_a_s2, pos_b_s2;

	always_comb begin
		for (int k = 0; k < 9; k++)
			back_ref[k] = have_first_q ? first_q[k] : frame[k];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_first_q <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (acc)
				have_first_q <= !closes;
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// frame storage and products
	always_ff @(posedge clk) begin
		if (acc) begin
			if (!have_first_q)
				first_q <= frame;
			prev_q <= frame;
			has_s1 <= have_first_q;
			cls_s1 <= closes;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					for (int c = 0; c < 3; c++) begin
						prod_a_s1[i*3+j][c] <= prev_q[i*3+c] * frame[j*3+c];
						prod_b_s1[i*3+j][c] <= frame[i*3+c] * back_ref[j*3+c];
					end
		end
	end

	logic signed [MAG_W-1:0] dot_a [9];
	logic signed [MAG_W-1:0] dot_b [9];

	always_comb begin
		for (int k = 0; k < 9; k++) begin
			dot_a[k] = MAG_W'(prod_a_s1[k][0]) + MAG_W'(prod_a_s1[k][1])
				+ MAG_W'(prod_a_s1[k][2]);
			dot_b[k] = MAG_W'(prod_b_s1[k][0]) + MAG_W'(prod_b_s1[k][1])
				+ MAG_W'(prod_b_s1[k][2]);
		end
	end

	always_ff @(posedge clk) begin
		has_s2 <= has_s1;
		cls_s2 <= cls_s1;
		has_s3 <= has_s2;
		cls_s3 <= cls_s2;
		has_s4 <= has_s3;
		cls_s4 <= cls_s3;
		for (int k = 0; k < 9; k++) begin
			mag_a_s2[k] <= dot_a[k][MAG_W-1] ? MAG_W'(-dot_a[k]) : MAG_W'(dot_a[k]);
			mag_b_s2[k] <= dot_b[k][MAG_W-1] ? MAG_W'(-dot_b[k]) : MAG_W'(dot_b[k]);
			pos_a_s2[k] <= !dot_a[k][MAG_W-1] && (dot_a[k] != '0);
			pos_b_s2[k] <= !dot_b[k][MAG_W-1] && (dot_b[k] != '0);
		end
	end

	fcst_map_t map_a_s4, map_b_s4;

	fcst_match #(.MAG_W(MAG_W)) u_match_a (
		.clk    (clk),
		.mag    (mag_a_s2),
		.pos    (pos_a_s2),
		.map_s4 (map_a_s4)
	);

	fcst_match #(.MAG_W(MAG_W)) u_match_b (
		.clk    (clk),
		.mag    (mag_b_s2),
		.pos    (pos_b_s2),
		.map_s4 (map_b_s4)
	);

	assign inflight = 3'(v_s1) + 3'(v_s2) + 3'(v_s3) + 3'(v_s4);
	assign push     = v_s4;
	assign step     = '{has_step: has_s4, closes: cls_s4, step_a: map_a_s4, step_b: map_b_s4};

endmodule

// File: hdl/fcst_queue.sv
// ----------------------------------------------------------------------------
// fcst_queue
// short register queue between front and back
// ----------------------------------------------------------------------------
module fcst_queue (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	input  fcst_pkg::fcst_step_t                 wdata,
	input  logic                                 pop,
	output logic                                 nonempty,
	output fcst_pkg::fcst_step_t                 rdata,
	output logic [fcst_pkg::QUEUE_CNT_W-1:0]     count
);
	import fcst_pkg::*;

	fcst_step_t             mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_q, rd_q;
	logic [QUEUE_CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

	assign nonempty = (cnt_q != '0);
	assign rdata    = mem_q[rd_q];
	assign count    = cnt_q;

endmodule

// File: hdl/fcst_back.sv
// ----------------------------------------------------------------------------
// fcst_back
// composes step permutations onto the cycle mapping and holds the result
// ----------------------------------------------------------------------------
module fcst_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_nonempty,
	input  fcst_pkg::fcst_step_t   q_data,
	output logic                   q_pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output fcst_pkg::fcst_map_t    out_map,
	output logic                   out_singular
);
	import fcst_pkg::*;

	fcst_map_t cycle_q, c1, c2;
	logic      out_valid_q;

	assign c1    = q_data.has_step ? compose(cycle_q, q_data.step_a) : cycle_q;
	assign c2    = compose(c1, q_data.step_b);
	assign q_pop = q_nonempty && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_q     <= IDENT_MAP;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (q_pop) begin
				if (q_data.closes) begin
					cycle_q     <= IDENT_MAP;
					out_valid_q <= 1'b1;
				end else begin
					cycle_q <= c1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_data.closes) begin
			out_map      <= c2;
			out_singular <= (c2 != IDENT_MAP);
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: hdl/frame_cycle_singularity_test_core.sv
// ----------------------------------------------------------------------------
// frame_cycle_singularity_test_core
// closes a cycle of three-axis frames and flags a non-identity mapping
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid/in_ready carries one frame per transaction, nine
//   signed components plus closes_cycle marking the last frame of a cycle
//   output channel out_valid/out_ready carries one transaction per closed
//   cycle: singular, perm_0..perm_2 and neg_0..neg_2
//   throughput: one frame per cycle while in_ready is high; the four-stage
//   front pipeline (products, dot sums, first pick, second pick) feeds an
//   eight-entry queue; a closing frame passes the front pipeline, the queue
//   and the output register before out_valid rises when the receiver is ready
//   in_ready drops only when queue entries plus frames in the front pipeline
//   reach the queue depth, so a stalled receiver backs up into the queue first
//   reset clears the cycle mapping to identity and forgets the first frame;
//   the output register holds its transaction until out_ready
// ----------------------------------------------------------------------------
module frame_cycle_singularity_test_core #(
	parameter int COMP_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [COMP_BITS-1:0] x_axis_x,
	input  logic signed [COMP_BITS-1:0] x_axis_y,
	input  logic signed [COMP_BITS-1:0] x_axis_z,
	input  logic signed [COMP_BITS-1:0] y_axis_x,
	input  logic signed [COMP_BITS-1:0] y_axis_y,
	input  logic signed [COMP_BITS-1:0] y_axis_z,
	input  logic signed [COMP_BITS-1:0] z_axis_x,
	input  logic signed [COMP_BITS-1:0] z_axis_y,
	input  logic signed [COMP_BITS-1:0] z_axis_z,
	input  logic                        closes_cycle,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        singular,
	output logic [1:0]                  perm_0,
	output logic [1:0]                  perm_1,
	output logic [1:0]                  perm_2,
	output logic                        neg_0,
	output logic                        neg_1,
	output logic                        neg_2
);
	import fcst_pkg::*;

	logic signed [COMP_BITS-1:0] frame [9];
	logic                        acc;
	logic [2:0]                  inflight;
	logic                        push, pop, nonempty;
	fcst_step_t                  push_data, head;
	logic [QUEUE_CNT_W-1:0]      q_count;
	logic [QUEUE_CNT_W:0]        used;
	fcst_map_t                   out_map;

	// component order: axis major, component minor
	assign frame[0] = x_axis_x;
	assign frame[1] = x_axis_y;
	assign frame[2] = x_axis_z;
	assign frame[3] = y_axis_x;
	assign frame[4] = y_axis_y;
	assign frame[5] = y_axis_z;
	assign frame[6] = z_axis_x;
	assign frame[7] = z_axis_y;
	assign frame[8] = z_axis_z;

	// credit check: every frame in flight has a queue slot waiting for it
	assign used     = (QUEUE_CNT_W+1)'(q_count) + (QUEUE_CNT_W+1)'(inflight);
	assign in_ready = used < (QUEUE_CNT_W+1)'(QUEUE_DEPTH);
	assign acc      = in_valid && in_ready;

	fcst_front #(.COMP_BITS(COMP_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.frame    (frame),
		.closes   (closes_cycle),
		.inflight (inflight),
		.push     (push),
		.step     (push_data)
	);

	fcst_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    (push_data),
		.pop      (pop),
		.nonempty (nonempty),
		.rdata    (head),
		.count    (q_count)
	);

	fcst_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_nonempty   (nonempty),
		.q_data       (head),
		.q_pop        (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_map      (out_map),
		.out_singular (singular)
	);

	assign perm_0 = out_map.perm[0];
	assign perm_1 = out_map.perm[1];
	assign perm_2 = out_map.perm[2];
	assign neg_0  = out_map.sgn[0];
	assign neg_1  = out_map.sgn[1];
	assign neg_2  = out_map.sgn[2];

`include "frame_cycle_singularity_test_core_assert.svh"

	`FCST_ASSERT_NEVER(a_queue_overflow, push && !pop && (q_count == QUEUE_CNT_W'(QUEUE_DEPTH)), "queue overflow")
	`FCST_ASSERT_IMPL(a_singular_flag, out_valid, singular == (perm_0 != 2'd0 || perm_1 != 2'd1 || perm_2 != 2'd2 || neg_0 || neg_1 || neg_2), "singular flag mismatch")
	`FCST_ASSERT_IMPL(a_perm_valid, out_valid, perm_0 != perm_1 && perm_1 != perm_2 && perm_0 != perm_2 && perm_0 != 2'd3 && perm_1 != 2'd3 && perm_2 != 2'd3, "output mapping is not a permutation")

endmodule
